FILE: hdl/asqt_pkg.sv
// asqt_pkg: shared types, constants and helper functions for the sprite quad transform
// used by the setup and rotate stages, the testbench and the top level
// no dependencies
package asqt_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register index codes (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_PIXEL_SCALE = 2'd0,
    REG_INV_WIDTH   = 2'd1,
    REG_INV_HEIGHT  = 2'd2
  } cfg_index_t;

  // reset values of the configuration registers
  localparam logic [23:0] PIXEL_SCALE_RST = 24'd65536;
  localparam logic [24:0] INV_ATLAS_RST   = 25'd4096;

  // angle constants in Q30 radians
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;

  // texture coordinate of 1.0 in Q0.16
  localparam logic [16:0] UV_ONE = 17'h10000;

  // widths of internal values
  localparam int OFS_W  = 46;  // scaled corner offset, Q16.16 with headroom
  localparam int TRIG_W = 18;  // sine / cosine, signed Q1.16

  typedef struct packed {
    logic [23:0] pixel_scale;
    logic [24:0] inv_atlas_width;
    logic [24:0] inv_atlas_height;
  } cfg_t;

  // one sprite after setup, ready for the per-corner rotation
  typedef struct packed {
    logic signed [OFS_W-1:0]  lx;
    logic signed [OFS_W-1:0]  rx;
    logic signed [OFS_W-1:0]  by;
    logic signed [OFS_W-1:0]  ty;
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
    logic signed [31:0]       px;
    logic signed [31:0]       py;
    logic [16:0]              u0;
    logic [16:0]              u1;
    logic [16:0]              vt;
    logic [16:0]              vb;
  } sprite_t;

  // sine in Q1.16 of theta in [0, 2pi) Q30, odd series to the 11th power
  function automatic longint sine_q16(input longint theta_in);
    longint theta;
    longint t;
    longint sum;
    logic   neg;
    theta = theta_in;
    neg   = 1'b0;
    if (theta >= PI_Q30) begin
      theta = theta - PI_Q30;
      neg   = 1'b1;
    end
    if (theta > HALF_PI_Q30) theta = PI_Q30 - theta;
    t   = theta;
    sum = theta;
    t   = (t * theta) >>> 30;
    t   = ((t * theta) >>> 30) / 6;
    sum = sum - t;
    t   = (t * theta) >>> 30;
    t   = ((t * theta) >>> 30) / 20;
    sum = sum + t;
    t   = (t * theta) >>> 30;
    t   = ((t * theta) >>> 30) / 42;
    sum = sum - t;
    t   = (t * theta) >>> 30;
    t   = ((t * theta) >>> 30) / 72;
    sum = sum + t;
    t   = (t * theta) >>> 30;
    t   = ((t * theta) >>> 30) / 110;
    sum = sum - t;
    if (sum < 0) sum = 0;
    sum = (sum + 8192) >>> 14;
    if (sum > 65536) sum = 65536;
    return neg ? -sum : sum;
  endfunction

  // shift right with rounding half away from zero
  function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                     input int unsigned s);
    logic signed [65:0] h;
    logic signed [65:0] m;
    h = 66'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + h) >>> s;
    end
    m = -v;
    return -((m + h) >>> s);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // edge times reciprocal product to Q0.16, clamped at 1.0
  function automatic logic [16:0] uv_sat(input logic [36:0] p);
    logic [37:0] t;
    t = (38'(p) + 38'd128) >> 8;
    if (t > 38'(UV_ONE)) return UV_ONE;
    return t[16:0];
  endfunction

endpackage

FILE: hdl/asqt_sprite_if.sv
// asqt_sprite_if: valid/ready channel carrying one sprite description
// no dependencies
interface asqt_sprite_if;
  logic               valid;
  logic               ready;
  logic [11:0]        frame_left;
  logic [11:0]        frame_right;
  logic [11:0]        frame_upper;
  logic [11:0]        frame_lower;
  logic [15:0]        anchor_x;
  logic [15:0]        anchor_y;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic [15:0]        angle;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               mirror;

  modport source (
    output valid, frame_left, frame_right, frame_upper, frame_lower, anchor_x, anchor_y,
    output scale_x, scale_y, angle, pos_x, pos_y, mirror,
    input  ready
  );
  modport sink (
    input  valid, frame_left, frame_right, frame_upper, frame_lower, anchor_x, anchor_y,
    input  scale_x, scale_y, angle, pos_x, pos_y, mirror,
    output ready
  );
endinterface

FILE: hdl/asqt_vertex_if.sv
// asqt_vertex_if: valid/ready channel carrying one quad vertex
// no dependencies
interface asqt_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [1:0]         corner;
  logic               last;

  modport source (
    output valid, vert_x, vert_y, tex_u, tex_v, corner, last,
    input  ready
  );
  modport sink (
    input  valid, vert_x, vert_y, tex_u, tex_v, corner, last,
    output ready
  );
endinterface

FILE: hdl/anchored_sprite_quad_transform_unit.sv
// anchored_sprite_quad_transform_unit: top level, configuration registers and the two pipelines
// depends on asqt_pkg, asqt_sprite_if, asqt_vertex_if, asqt_setup, asqt_rotate
//
// Usage
//   in_chan  : one sprite per transfer (frame edges, anchor, scale, angle, position, mirror)
//   out_chan : four vertex transfers per sprite, corners bottom-left, bottom-right,
//              top-right, top-left; last is set on the fourth
//   cfg_*    : APB-style port, pixel_scale at 0x0, inv_atlas_width at 0x4,
//              inv_atlas_height at 0x8; write only while the block is idle
// Path: a sprite passes the four setup stages, the corner hold register and the four
//   rotate stages on its way to its first vertex.
// Throughput: one vertex per cycle while the receiver holds ready high, set by the single
//   rotate datapath that the four corners of a sprite share. Sprites are accepted in
//   consecutive cycles until the setup stages fill.
// Reset (synchronous, rst_n low) clears all valid bits and the corner counter and
//   loads the registers with their reset values; no clearing pass is needed.
// When the receiver holds ready low, the output vertex holds and the stages behind
//   it fill and then stop; in_chan.ready falls once every stage is occupied.
module anchored_sprite_quad_transform_unit
  import asqt_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  asqt_sprite_if.sink            in_chan,
  asqt_vertex_if.source          out_chan,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t       cfg_r;
  cfg_index_t reg_idx;
  logic       wr_en;
  logic       spr_valid, spr_ready;
  sprite_t    spr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_index_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_scale      <= PIXEL_SCALE_RST;
      cfg_r.inv_atlas_width  <= INV_ATLAS_RST;
      cfg_r.inv_atlas_height <= INV_ATLAS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PIXEL_SCALE: cfg_r.pixel_scale      <= cfg_pwdata[23:0];
        REG_INV_WIDTH:   cfg_r.inv_atlas_width  <= cfg_pwdata[24:0];
        REG_INV_HEIGHT:  cfg_r.inv_atlas_height <= cfg_pwdata[24:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_PIXEL_SCALE: cfg_prdata = {8'd0, cfg_r.pixel_scale};
      REG_INV_WIDTH:   cfg_prdata = {7'd0, cfg_r.inv_atlas_width};
      REG_INV_HEIGHT:  cfg_prdata = {7'd0, cfg_r.inv_atlas_height};
      default:         cfg_prdata = '0;
    endcase
  end

  // per-sprite setup
  asqt_setup #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_chan   (in_chan),
    .spr_valid (spr_valid),
    .spr_ready (spr_ready),
    .spr       (spr)
  );

  // per-corner rotate and translate
  asqt_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .spr_valid (spr_valid),
    .spr_ready (spr_ready),
    .spr       (spr),
    .out_chan  (out_chan)
  );

endmodule

FILE: hdl/asqt_setup.sv
// asqt_setup: four-stage per-sprite pipeline: corner offsets, trig table, texture coords
// depends on asqt_pkg and asqt_sprite_if
module asqt_setup
  import asqt_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  asqt_sprite_if.sink  in_chan,
  output logic         spr_valid,
  input  logic         spr_ready,
  output sprite_t      spr
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

  typedef struct packed {
    logic signed [17:0] d_lx;
    logic signed [17:0] d_rx;
    logic signed [17:0] d_by;
    logic signed [17:0] d_ty;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [IDX_W-1:0]   idx;
    logic [36:0]        p_u0;
    logic [36:0]        p_u1;
    logic [36:0]        p_vt;
    logic [36:0]        p_vb;
    logic               swap;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } st1_t;

  typedef struct packed {
    logic signed [41:0] m_lx;
    logic signed [41:0] m_rx;
    logic signed [41:0] m_by;
    logic signed [41:0] m_ty;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
    logic [16:0]        u0;
    logic [16:0]        u1;
    logic [16:0]        vt;
    logic [16:0]        vb;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } st2_t;

  typedef struct packed {
    logic signed [57:0] q_lx;
    logic signed [57:0] q_rx;
    logic signed [57:0] q_by;
    logic signed [57:0] q_ty;
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
    logic [16:0]        u0;
    logic [16:0]        u1;
    logic [16:0]        vt;
    logic [16:0]        vb;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } st3_t;

  // constant sine and cosine tables, one entry per quantized angle
  logic signed [TRIG_W-1:0] sin_tab [SINE_TABLE_DEPTH];
  logic signed [TRIG_W-1:0] cos_tab [SINE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_tab
    localparam longint Th  = longint'(gi) * TWO_PI_Q30 / SINE_TABLE_DEPTH;
    localparam longint Ct0 = Th + HALF_PI_Q30;
    localparam longint Ct  = (Ct0 >= TWO_PI_Q30) ? Ct0 - TWO_PI_Q30 : Ct0;
    assign sin_tab[gi] = TRIG_W'(sine_q16(Th));
    assign cos_tab[gi] = TRIG_W'(sine_q16(Ct));
  end

  st1_t    st1_r, st1_nxt;
  st2_t    st2_r, st2_nxt;
  st3_t    st3_r, st3_nxt;
  sprite_t st4_r, st4_nxt;
  logic    v1_r, v2_r, v3_r, v4_r;
  logic    e1, e2, e3, e4;

  logic [11:0]   wid, hgt;
  logic [32:0]   idx_full;
  logic [41:0]   ps_ext;

  // stage enables: a stage moves when it is empty or its successor moves
  assign e4 = !v4_r || spr_ready;
  assign e3 = !v3_r || e4;
  assign e2 = !v2_r || e3;
  assign e1 = !v1_r || e2;
  assign in_chan.ready = e1;

  // stage 1: extents, anchor-relative offsets, table index, texture products
  always_comb begin
    wid = (in_chan.frame_left > in_chan.frame_right) ?
          in_chan.frame_left - in_chan.frame_right : in_chan.frame_right - in_chan.frame_left;
    hgt = (in_chan.frame_upper > in_chan.frame_lower) ?
          in_chan.frame_upper - in_chan.frame_lower : in_chan.frame_lower - in_chan.frame_upper;
    idx_full = 33'(in_chan.angle) * 33'(SINE_TABLE_DEPTH);
    st1_nxt.d_lx = -$signed({2'b00, in_chan.anchor_x});
    st1_nxt.d_rx = $signed({2'b00, wid, 4'b0000}) - $signed({2'b00, in_chan.anchor_x});
    st1_nxt.d_by = -$signed({2'b00, in_chan.anchor_y});
    st1_nxt.d_ty = $signed({2'b00, hgt, 4'b0000}) - $signed({2'b00, in_chan.anchor_y});
    st1_nxt.sx   = in_chan.scale_x;
    st1_nxt.sy   = in_chan.scale_y;
    st1_nxt.idx  = idx_full[16 +: IDX_W];
    st1_nxt.p_u0 = 37'(in_chan.frame_left) * 37'(cfg.inv_atlas_width);
    st1_nxt.p_u1 = 37'(in_chan.frame_right) * 37'(cfg.inv_atlas_width);
    st1_nxt.p_vt = 37'(in_chan.frame_upper) * 37'(cfg.inv_atlas_height);
    st1_nxt.p_vb = 37'(in_chan.frame_lower) * 37'(cfg.inv_atlas_height);
    st1_nxt.swap = in_chan.mirror && (in_chan.angle > 16'd16384) &&
                   (in_chan.angle <= 16'd49152);
    st1_nxt.px   = in_chan.pos_x;
    st1_nxt.py   = in_chan.pos_y;
  end

  // stage 2: offset times pixel scale, table read, texture rounding and flip
  always_comb begin
    ps_ext       = {18'd0, cfg.pixel_scale};
    st2_nxt.m_lx = 42'(st1_r.d_lx) * $signed(ps_ext);
    st2_nxt.m_rx = 42'(st1_r.d_rx) * $signed(ps_ext);
    st2_nxt.m_by = 42'(st1_r.d_by) * $signed(ps_ext);
    st2_nxt.m_ty = 42'(st1_r.d_ty) * $signed(ps_ext);
    st2_nxt.sx   = st1_r.sx;
    st2_nxt.sy   = st1_r.sy;
    st2_nxt.sn   = sin_tab[st1_r.idx];
    st2_nxt.cs   = cos_tab[st1_r.idx];
    st2_nxt.u0   = uv_sat(st1_r.p_u0);
    st2_nxt.u1   = uv_sat(st1_r.p_u1);
    st2_nxt.vt   = st1_r.swap ? uv_sat(st1_r.p_vb) : uv_sat(st1_r.p_vt);
    st2_nxt.vb   = st1_r.swap ? uv_sat(st1_r.p_vt) : uv_sat(st1_r.p_vb);
    st2_nxt.px   = st1_r.px;
    st2_nxt.py   = st1_r.py;
  end

  // stage 3: times the sprite scale
  always_comb begin
    st3_nxt.q_lx = 58'(st2_r.m_lx) * 58'(st2_r.sx);
    st3_nxt.q_rx = 58'(st2_r.m_rx) * 58'(st2_r.sx);
    st3_nxt.q_by = 58'(st2_r.m_by) * 58'(st2_r.sy);
    st3_nxt.q_ty = 58'(st2_r.m_ty) * 58'(st2_r.sy);
    st3_nxt.sn   = st2_r.sn;
    st3_nxt.cs   = st2_r.cs;
    st3_nxt.u0   = st2_r.u0;
    st3_nxt.u1   = st2_r.u1;
    st3_nxt.vt   = st2_r.vt;
    st3_nxt.vb   = st2_r.vb;
    st3_nxt.px   = st2_r.px;
    st3_nxt.py   = st2_r.py;
  end

  // stage 4: round back to Q16.16
  always_comb begin
    st4_nxt.lx = OFS_W'(round_shift(66'(st3_r.q_lx), 12));
    st4_nxt.rx = OFS_W'(round_shift(66'(st3_r.q_rx), 12));
    st4_nxt.by = OFS_W'(round_shift(66'(st3_r.q_by), 12));
    st4_nxt.ty = OFS_W'(round_shift(66'(st3_r.q_ty), 12));
    st4_nxt.sn = st3_r.sn;
    st4_nxt.cs = st3_r.cs;
    st4_nxt.px = st3_r.px;
    st4_nxt.py = st3_r.py;
    st4_nxt.u0 = st3_r.u0;
    st4_nxt.u1 = st3_r.u1;
    st4_nxt.vt = st3_r.vt;
    st4_nxt.vb = st3_r.vb;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (e1) v1_r <= in_chan.valid;
      if (e2) v2_r <= v1_r;
      if (e3) v3_r <= v2_r;
      if (e4) v4_r <= v3_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (e1) st1_r <= st1_nxt;
    if (e2) st2_r <= st2_nxt;
    if (e3) st3_r <= st3_nxt;
    if (e4) st4_r <= st4_nxt;
  end

  assign spr_valid = v4_r;
  assign spr       = st4_r;

endmodule

FILE: hdl/asqt_rotate.sv
// asqt_rotate: holds one sprite, steps its four corners through rotate and translate stages
// depends on asqt_pkg and asqt_vertex_if
module asqt_rotate
  import asqt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          spr_valid,
  output logic          spr_ready,
  input  sprite_t       spr,
  asqt_vertex_if.source out_chan
);

  typedef struct packed {
    logic [16:0] u;
    logic [16:0] v;
    logic [1:0]  corner;
    logic        last;
  } tag_t;

  typedef struct packed {
    logic signed [63:0] pcx;
    logic signed [63:0] psy;
    logic signed [63:0] pcy;
    logic signed [63:0] psx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    tag_t               tag;
  } r1_t;

  typedef struct packed {
    logic signed [64:0] xs;
    logic signed [64:0] ys;
    logic signed [31:0] px;
    logic signed [31:0] py;
    tag_t               tag;
  } r2_t;

  typedef struct packed {
    logic signed [49:0] xr;
    logic signed [49:0] yr;
    tag_t               tag;
  } r3_t;

  sprite_t hold_r;
  logic    hold_v_r, hold_v_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic    load, adv;
  logic    v1_r, v2_r, v3_r, v4_r;
  logic    e1, e2, e3, e4;
  r1_t     r1_r, r1_nxt;
  r2_t     r2_r, r2_nxt;
  r3_t     r3_r, r3_nxt;
  logic signed [31:0] ox_r, oy_r;
  tag_t    otag_r;
  logic signed [OFS_W-1:0] cx, cy;

  // stage enables
  assign e4 = !v4_r || out_chan.ready;
  assign e3 = !v3_r || e4;
  assign e2 = !v2_r || e3;
  assign e1 = !v1_r || e2;

  // corner sequencing: a new sprite loads when none is held or when the held one sends its last corner
  assign adv       = e1 && hold_v_r;
  assign load      = !hold_v_r || (adv && (cnt_r == 2'd3));
  assign spr_ready = load;

  always_comb begin
    cnt_nxt    = adv ? cnt_r + 2'd1 : cnt_r;
    hold_v_nxt = load ? spr_valid : hold_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      hold_v_r <= hold_v_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) hold_r <= spr;
  end

  // stage 1: pick the corner and form the four rotation products
  always_comb begin
    cx = ((cnt_r == 2'd0) || (cnt_r == 2'd3)) ? hold_r.lx : hold_r.rx;
    cy = ((cnt_r == 2'd0) || (cnt_r == 2'd1)) ? hold_r.by : hold_r.ty;
    r1_nxt.pcx = 64'(hold_r.cs) * 64'(cx);
    r1_nxt.psy = 64'(hold_r.sn) * 64'(cy);
    r1_nxt.pcy = 64'(hold_r.cs) * 64'(cy);
    r1_nxt.psx = 64'(hold_r.sn) * 64'(cx);
    r1_nxt.px  = hold_r.px;
    r1_nxt.py  = hold_r.py;
    r1_nxt.tag.u      = ((cnt_r == 2'd0) || (cnt_r == 2'd3)) ? hold_r.u0 : hold_r.u1;
    r1_nxt.tag.v      = ((cnt_r == 2'd0) || (cnt_r == 2'd1)) ? hold_r.vb : hold_r.vt;
    r1_nxt.tag.corner = cnt_r;
    r1_nxt.tag.last   = (cnt_r == 2'd3);
  end

  // stage 2: combine products
  always_comb begin
    r2_nxt.xs  = 65'(r1_r.pcx) - 65'(r1_r.psy);
    r2_nxt.ys  = 65'(r1_r.pcy) + 65'(r1_r.psx);
    r2_nxt.px  = r1_r.px;
    r2_nxt.py  = r1_r.py;
    r2_nxt.tag = r1_r.tag;
  end

  // stage 3: round to Q16.16 and translate
  always_comb begin
    r3_nxt.xr  = 50'(round_shift(66'(r2_r.xs), 16)) + 50'(r2_r.px);
    r3_nxt.yr  = 50'(round_shift(66'(r2_r.ys), 16)) + 50'(r2_r.py);
    r3_nxt.tag = r2_r.tag;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (e1) v1_r <= hold_v_r;
      if (e2) v2_r <= v1_r;
      if (e3) v3_r <= v2_r;
      if (e4) v4_r <= v3_r;
    end
  end

  // payload registers, last stage saturates into the output register
  always_ff @(posedge clk) begin
    if (e1) r1_r <= r1_nxt;
    if (e2) r2_r <= r2_nxt;
    if (e3) r3_r <= r3_nxt;
    if (e4) begin
      ox_r   <= sat32(r3_r.xr);
      oy_r   <= sat32(r3_r.yr);
      otag_r <= r3_r.tag;
    end
  end

  assign out_chan.valid  = v4_r;
  assign out_chan.vert_x = ox_r;
  assign out_chan.vert_y = oy_r;
  assign out_chan.tex_u  = otag_r.u;
  assign out_chan.tex_v  = otag_r.v;
  assign out_chan.corner = otag_r.corner;
  assign out_chan.last   = otag_r.last;

  // corner count rests at zero while no sprite is held
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_v_r |-> (cnt_r == 2'd0))
    else $error("corner count nonzero with no sprite held");

  // a sprite is taken only on a quad boundary
  a_load_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (spr_valid && spr_ready) |-> (!hold_v_r || (cnt_r == 2'd3)))
    else $error("sprite loaded mid-quad");

  // a held sprite stays until its fourth corner has gone
  a_hold_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && !(adv && (cnt_r == 2'd3))) |=> hold_v_r)
    else $error("held sprite dropped before its last corner");

  // last marks exactly the top-left corner
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (otag_r.last == (otag_r.corner == 2'd3)))
    else $error("last flag out of step with corner");

endmodule

FILE: sim/tb_anchored_sprite_quad_transform_unit.sv
// tb_anchored_sprite_quad_transform_unit: self-checking testbench for the sprite quad transform
// depends on asqt_pkg, asqt_sprite_if, asqt_vertex_if and anchored_sprite_quad_transform_unit
// predicts the four vertices of each sprite and checks every output transfer in order
`timescale 1ns / 100ps

module tb_anchored_sprite_quad_transform_unit
  import asqt_pkg::*;
();

  localparam int TABLE_DEPTH = 1024;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;

  typedef struct {
    logic [11:0]        frame_left;
    logic [11:0]        frame_right;
    logic [11:0]        frame_upper;
    logic [11:0]        frame_lower;
    logic [15:0]        anchor_x;
    logic [15:0]        anchor_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [15:0]        angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               mirror;
  } sprite_desc_t;

  typedef struct {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [1:0]         corner;
    logic               last;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  asqt_sprite_if in_if ();
  asqt_vertex_if out_if ();

  anchored_sprite_quad_transform_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // local copy of the registers
  logic [23:0] mdl_pixel_scale = 24'd65536;
  logic [24:0] mdl_inv_width   = 25'd4096;
  logic [24:0] mdl_inv_height  = 25'd4096;

  vertex_t expected_vertices[$];
  int      errors    = 0;
  bit      calm      = 0;  // no idling on either side
  int      hold_off  = 0;  // receiver stall length in cycles

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // half away from zero
  function automatic longint round_away(input longint v, input int s);
    longint h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q1.16 sine of a Q30 angle in [0, 2pi), odd series on the folded angle
  function automatic longint sine_of(input longint ang);
    longint a, term, acc;
    bit     flip;
    int     k;
    a    = ang;
    flip = 0;
    if (a >= Q30_PI) begin
      a    = a - Q30_PI;
      flip = 1;
    end
    if (a > Q30_HALF_PI) a = Q30_PI - a;
    term = a;
    acc  = a;
    for (k = 1; k <= 5; k++) begin
      term = (term * a) >>> 30;
      term = ((term * a) >>> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc < 0) acc = 0;
    acc = (acc + 8192) >>> 14;
    if (acc > 65536) acc = 65536;
    return flip ? -acc : acc;
  endfunction

  function automatic logic [16:0] texel(input logic [11:0] edge_px, input logic [24:0] inv);
    longint p;
    p = (longint'(edge_px) * longint'(inv) + 128) >>> 8;
    if (p > 65536) p = 65536;
    return p[16:0];
  endfunction

  function automatic longint corner_offset(input longint d, input longint s);
    return round_away(d * longint'(mdl_pixel_scale) * s, 12);
  endfunction

  // four expected vertices of one sprite
  task automatic predict_quad(input sprite_desc_t sp);
    longint w, h, ax, ay, sx, sy, lx, rx, by, ty, idx, th, cth, sn, cs;
    longint cx[4], cy[4];
    logic [16:0] u0, u1, vt, vb, tmp;
    vertex_t vx;
    ax  = longint'(sp.anchor_x);
    ay  = longint'(sp.anchor_y);
    sx  = longint'(sp.scale_x);
    sy  = longint'(sp.scale_y);
    w   = (sp.frame_left > sp.frame_right) ? longint'(sp.frame_left - sp.frame_right)
                                           : longint'(sp.frame_right - sp.frame_left);
    h   = (sp.frame_upper > sp.frame_lower) ? longint'(sp.frame_upper - sp.frame_lower)
                                            : longint'(sp.frame_lower - sp.frame_upper);
    lx  = corner_offset(-ax, sx);
    rx  = corner_offset(w * 16 - ax, sx);
    by  = corner_offset(-ay, sy);
    ty  = corner_offset(h * 16 - ay, sy);
    idx = (longint'(sp.angle) * TABLE_DEPTH) >>> 16;
    th  = idx * Q30_TWO_PI / TABLE_DEPTH;
    cth = th + Q30_HALF_PI;
    if (cth >= Q30_TWO_PI) cth = cth - Q30_TWO_PI;
    sn  = sine_of(th);
    cs  = sine_of(cth);
    u0  = texel(sp.frame_left, mdl_inv_width);
    u1  = texel(sp.frame_right, mdl_inv_width);
    vt  = texel(sp.frame_upper, mdl_inv_height);
    vb  = texel(sp.frame_lower, mdl_inv_height);
    // mirrored sprites past a quarter turn and up to three quarters flip vertically in texture space
    if (sp.mirror && sp.angle > 16384 && sp.angle <= 49152) begin
      tmp = vt;
      vt  = vb;
      vb  = tmp;
    end
    cx = '{lx, rx, rx, lx};
    cy = '{by, by, ty, ty};
    for (int k = 0; k < 4; k++) begin
      vx.vert_x = 32'(clamp32(round_away(cs * cx[k] - sn * cy[k], 16) + longint'(sp.pos_x)));
      vx.vert_y = 32'(clamp32(round_away(cs * cy[k] + sn * cx[k], 16) + longint'(sp.pos_y)));
      vx.tex_u  = (k == 0 || k == 3) ? u0 : u1;
      vx.tex_v  = (k < 2) ? vb : vt;
      vx.corner = 2'(k);
      vx.last   = (k == 3);
      expected_vertices.push_back(vx);
    end
  endtask

  // receiver ready, with random stalls and a counted hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_if.ready = 1'b0;
      hold_off = hold_off - 1;
    end else begin
      out_if.ready = calm || ($urandom_range(99) >= 36);
    end
  end

  // check each output transfer against the oldest expected vertex
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d u=%0d v=%0d corner=%0d", $time,
                 out_if.vert_x, out_if.vert_y, out_if.tex_u, out_if.tex_v, out_if.corner);
        errors++;
      end else begin
        e = expected_vertices.pop_front();
        if (out_if.vert_x !== e.vert_x || out_if.vert_y !== e.vert_y ||
            out_if.tex_u !== e.tex_u || out_if.tex_v !== e.tex_v ||
            out_if.corner !== e.corner || out_if.last !== e.last) begin
          $display("%0t: mismatch expected x=%0d y=%0d u=%0d v=%0d corner=%0d last=%0d",
                   $time, e.vert_x, e.vert_y, e.tex_u, e.tex_v, e.corner, e.last);
          $display("%0t:          actual   x=%0d y=%0d u=%0d v=%0d corner=%0d last=%0d",
                   $time, out_if.vert_x, out_if.vert_y, out_if.tex_u, out_if.tex_v,
                   out_if.corner, out_if.last);
          errors++;
        end
      end
    end
  end

  // one sprite transfer, valid stays high afterwards
  task automatic send_sprite(input sprite_desc_t sp);
    if (!calm && $urandom_range(99) < 36) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_if.frame_left  = sp.frame_left;
    in_if.frame_right = sp.frame_right;
    in_if.frame_upper = sp.frame_upper;
    in_if.frame_lower = sp.frame_lower;
    in_if.anchor_x    = sp.anchor_x;
    in_if.anchor_y    = sp.anchor_y;
    in_if.scale_x     = sp.scale_x;
    in_if.scale_y     = sp.scale_y;
    in_if.angle       = sp.angle;
    in_if.pos_x       = sp.pos_x;
    in_if.pos_y       = sp.pos_y;
    in_if.mirror      = sp.mirror;
    in_if.valid       = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    predict_quad(sp);
    @(negedge clk);
  endtask

  // drop valid and let the pipeline empty
  task automatic drain;
    in_if.valid = 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_PIXEL_SCALE: mdl_pixel_scale = value[23:0];
      REG_INV_WIDTH:   mdl_inv_width   = value[24:0];
      REG_INV_HEIGHT:  mdl_inv_height  = value[24:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  function automatic sprite_desc_t random_sprite();
    sprite_desc_t sp;
    sp.frame_left  = 12'($urandom);
    sp.frame_right = 12'($urandom);
    sp.frame_upper = 12'($urandom);
    sp.frame_lower = 12'($urandom);
    sp.anchor_x    = 16'($urandom);
    sp.anchor_y    = 16'($urandom);
    sp.scale_x     = 16'($urandom);
    sp.scale_y     = 16'($urandom);
    sp.angle       = 16'($urandom);
    sp.pos_x       = $urandom;
    sp.pos_y       = $urandom;
    sp.mirror      = 1'($urandom);
    // mostly modest sprites so that saturation stays the exception
    if ($urandom_range(3) != 0) begin
      sp.frame_right = sp.frame_left + 12'($urandom_range(255));
      sp.anchor_x    = 16'($urandom_range(4095));
      sp.anchor_y    = 16'($urandom_range(4095));
      sp.scale_x     = 16'($signed($urandom_range(1024)) - 512);
      sp.scale_y     = 16'($signed($urandom_range(1024)) - 512);
      sp.pos_x       = $signed($urandom_range(32'h0fffffff)) - 32'sh08000000;
    end
    return sp;
  endfunction

  function automatic sprite_desc_t plain_sprite(input logic [15:0] ang, input logic mir);
    sprite_desc_t sp;
    sp = '{12'd10, 12'd42, 12'd100, 12'd164, 16'd256, 16'd512, 16'sd256, 16'sd256,
           ang, 32'sd65536, -32'sd131072, mir};
    return sp;
  endfunction

  // field extremes, saturation and reversed edges
  task automatic test_extremes;
    sprite_desc_t sp;
    sp = '{12'd0, 12'd4095, 12'd0, 12'd4095, 16'd0, 16'd0, 16'sd32767, 16'sd32767,
           16'd0, 32'sh7fffffff, 32'sh7fffffff, 1'b0};
    send_sprite(sp);
    sp = '{12'd4095, 12'd0, 12'd4095, 12'd0, 16'hffff, 16'hffff, -16'sd32768, -16'sd32768,
           16'hffff, 32'sh80000000, 32'sh80000000, 1'b1};
    send_sprite(sp);
    sp = '{12'd7, 12'd7, 12'd9, 12'd9, 16'd0, 16'd0, 16'sd256, -16'sd256,
           16'd8192, 32'sd0, 32'sd0, 1'b1};
    send_sprite(sp);
    sp = '{12'd300, 12'd100, 12'd50, 12'd20, 16'd800, 16'd160, -16'sd128, 16'sd512,
           16'd40000, -32'sd1000000, 32'sd1000000, 1'b0};
    send_sprite(sp);
    drain();
  endtask

  // the mirror window edges on both sides of the quarter turns
  task automatic test_mirror_angles;
    logic [15:0] angles[8];
    angles = '{16'd0, 16'd16383, 16'd16384, 16'd16385, 16'd32768, 16'd49152, 16'd49153,
               16'd65535};
    foreach (angles[i]) begin
      send_sprite(plain_sprite(angles[i], 1'b1));
      send_sprite(plain_sprite(angles[i], 1'b0));
    end
    drain();
  endtask

  // register settings, including zero and oversized reciprocals
  task automatic test_register_settings;
    write_reg(REG_PIXEL_SCALE, 32'h00ffffff);
    write_reg(REG_INV_WIDTH, 32'h01ffffff);
    write_reg(REG_INV_HEIGHT, 32'd0);
    send_sprite(plain_sprite(16'd1000, 1'b0));
    repeat (10) send_sprite(random_sprite());
    drain();
    write_reg(REG_PIXEL_SCALE, 32'd0);
    write_reg(REG_INV_WIDTH, 32'd1);
    write_reg(REG_INV_HEIGHT, 32'h01000000);
    send_sprite(plain_sprite(16'd30000, 1'b1));
    repeat (10) send_sprite(random_sprite());
    drain();
  endtask

  // random sprites under several settings, with a calm stretch and a long output stall
  task automatic test_random;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_PIXEL_SCALE, phase == 0 ? 32'd65536 : 32'($urandom_range(24'hffffff)));
      write_reg(REG_INV_WIDTH, 32'($urandom_range(25'h1000000, 1)));
      write_reg(REG_INV_HEIGHT, 32'($urandom_range(25'h1000000, 1)));
      calm = (phase == 1);
      if (phase == 2) hold_off = 200;
      repeat (45) send_sprite(random_sprite());
      calm = 0;
      drain();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_if.valid = 1'b0;
    in_if.frame_left = '0;  in_if.frame_right = '0;
    in_if.frame_upper = '0; in_if.frame_lower = '0;
    in_if.anchor_x = '0;    in_if.anchor_y = '0;
    in_if.scale_x = '0;     in_if.scale_y = '0;
    in_if.angle = '0;       in_if.pos_x = '0;
    in_if.pos_y = '0;       in_if.mirror = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_extremes();
    test_mirror_angles();
    test_register_settings();
    test_random();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
